// ----- rtl/sorted_list_insert_delete_macros.svh -----
// Assertion macros of the sorted list RTL, used by sli_ctrl.
`ifndef SORTED_LIST_INSERT_DELETE_MACROS_SVH
`define SORTED_LIST_INSERT_DELETE_MACROS_SVH

// Check a property on every clock edge, ignored while reset is held.
`define SLI_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SLI_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/sli_pkg.sv -----
// Types and constants of the sorted list insert/delete block.
package sli_pkg;

  localparam int DEPTH     = 16;
  localparam int IDX_W     = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int VAL_W     = 32;
  localparam int POS_W     = 4;
  localparam int CNT_OUT_W = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_DELETED   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_DROPPED   = 2'd3
  } status_t;

  typedef struct packed {
    logic                    mode;
    logic signed [VAL_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    status_t                 status;
    logic [POS_W-1:0]        position;
    logic [CNT_OUT_W-1:0]    entry_count;
    logic                    smallest_valid;
    logic signed [VAL_W-1:0] smallest_value;
  } out_item_t;

  // Compare results of one cell against the incoming value.
  typedef struct packed {
    logic le;
    logic lt;
    logic eq;
  } cell_flags_t;

endpackage

// ----- rtl/sli_cell.sv -----
// One list cell: holds an entry, compares it and shifts with its neighbors.
module sli_cell (
  input  logic                            clk,
  input  sli_pkg::in_item_t               item,
  input  logic                            wr,
  input  logic                            occupied,
  input  logic                            left_le,
  input  logic signed [sli_pkg::VAL_W-1:0] left_entry,
  input  logic signed [sli_pkg::VAL_W-1:0] right_entry,
  output sli_pkg::cell_flags_t            flags,
  output logic signed [sli_pkg::VAL_W-1:0] entry,
  output logic signed [sli_pkg::VAL_W-1:0] entry_nxt
);
  import sli_pkg::*;

  logic signed [VAL_W-1:0] entry_r;

  // Compare the stored entry with the incoming value
  always_comb begin
    flags.le = occupied && (entry_r <= item.value);
    flags.lt = occupied && (entry_r <  item.value);
    flags.eq = occupied && (entry_r == item.value);
  end

  // Pick the next entry: hold, take the new value, or shift from a neighbor
  always_comb begin
    entry_nxt = entry_r;
    if (wr) begin
      if (item.mode == MODE_DELETE) begin
        if (!flags.lt) begin
          entry_nxt = right_entry;
        end
      end else if (!flags.le) begin
        entry_nxt = left_le ? item.value : left_entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  assign entry = entry_r;

endmodule

// ----- rtl/sli_ctrl.sv -----
// Count, handshake, result encoding and output register of the sorted list.
`include "sorted_list_insert_delete_macros.svh"

module sli_ctrl (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  sli_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output sli_pkg::out_item_t                   out_data,
  input  sli_pkg::cell_flags_t [sli_pkg::DEPTH-1:0] flags,
  input  logic signed [sli_pkg::VAL_W-1:0]     head_nxt,
  output logic [sli_pkg::DEPTH-1:0]            occ,
  output logic                                 wr
);
  import sli_pkg::*;

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_r, out_nxt;

  logic             accept;
  logic             is_del;
  logic             full;
  logic             found;
  logic [DEPTH-1:0] ins_hot;
  logic [DEPTH-1:0] del_hot;
  logic [IDX_W-1:0] ins_pos;
  logic [IDX_W-1:0] del_pos;

  // Handshake: take a word unless a result is waiting and stalled
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_del   = (in_data.mode == MODE_DELETE);
  assign full     = (count_r == CNT_W'(DEPTH));

  // Mark the occupied cells
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      occ[i] = (CNT_W'(i) < count_r);
    end
  end

  // Find the insert slot and the first matching entry
  always_comb begin
    found   = 1'b0;
    ins_pos = '0;
    del_pos = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (i == 0) begin
        ins_hot[i] = !flags[i].le;
        del_hot[i] = flags[i].eq;
      end else begin
        ins_hot[i] = !flags[i].le && flags[i-1].le;
        del_hot[i] = flags[i].eq && !flags[i-1].eq;
      end
      found   = found | flags[i].eq;
      ins_pos = ins_pos | (ins_hot[i] ? IDX_W'(i) : '0);
      del_pos = del_pos | (del_hot[i] ? IDX_W'(i) : '0);
    end
  end

  assign wr = accept && (is_del ? found : !full);

  // Build the next count and the result word
  always_comb begin
    count_nxt = count_r;
    out_nxt   = out_r;
    if (accept) begin
      out_nxt.position = '0;
      if (is_del) begin
        if (found) begin
          count_nxt        = count_r - CNT_W'(1);
          out_nxt.status   = ST_DELETED;
          out_nxt.position = POS_W'(del_pos);
        end else begin
          out_nxt.status = ST_NOT_FOUND;
        end
      end else begin
        if (full) begin
          out_nxt.status = ST_DROPPED;
        end else begin
          count_nxt        = count_r + CNT_W'(1);
          out_nxt.status   = ST_INSERTED;
          out_nxt.position = POS_W'(ins_pos);
        end
      end
      out_nxt.entry_count    = CNT_OUT_W'(count_nxt);
      out_nxt.smallest_valid = (count_nxt != '0);
      out_nxt.smallest_value = (count_nxt != '0) ? head_nxt : '0;
    end
  end

  // Drop the result once taken, set it on a new word
  always_comb begin
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `SLI_ASSERT(a_count_bound, count_r <= CNT_W'(DEPTH), "entry count above depth")
  `SLI_ASSERT(a_count_hold, (!accept) |=> $stable(count_r), "count moved without a word")
  `SLI_ASSERT(a_drop_full, (accept && !is_del && full) |=> (out_r.status == ST_DROPPED), "insert into full store not dropped")
  `SLI_ASSERT(a_del_count, (accept && is_del && found) |=> (count_r == $past(count_r) - CNT_W'(1)), "delete did not shrink count")
  `SLI_ASSERT(a_head_flag, out_valid_r |-> (out_r.smallest_valid == (out_r.entry_count != '0)), "smallest flag disagrees with count")

endmodule

// ----- rtl/sorted_list_insert_delete.sv -----
// Top level of the sorted list: a row of compare-and-shift cells plus control.
//
//   channel  direction  handshake          word
//   in_      input      in_valid/in_stall  in_data  (mode, value)
//   out_     output     out_valid/out_stall out_data (status, position, count, smallest)
//
// One word per cycle while in_stall is low: every cell compares its entry with the value and shifts
// in the same cycle, so the single compare-and-shift step of a cell sets the rate.
// The result is registered at the edge that takes the word and is offered from the next cycle.
// Reset clears the entry count and the output valid flag; no clearing pass runs.
// in_stall rises only while a result waits in the output register with out_stall high.
module sorted_list_insert_delete (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  sli_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output sli_pkg::out_item_t out_data
);
  import sli_pkg::*;

  cell_flags_t [DEPTH-1:0] flags;
  logic signed [VAL_W-1:0] entry     [DEPTH];
  logic signed [VAL_W-1:0] entry_nxt [DEPTH];
  logic [DEPTH-1:0]        occ;
  logic                    wr;

  // Build the row of cells, each wired to its two neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                    left_le;
    logic signed [VAL_W-1:0] left_entry;
    logic signed [VAL_W-1:0] right_entry;

    if (i == 0) begin : g_first
      assign left_le    = 1'b1;
      assign left_entry = '0;
    end else begin : g_inner
      assign left_le    = flags[i-1].le;
      assign left_entry = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_entry = '0;
    end else begin : g_mid
      assign right_entry = entry[i+1];
    end

    sli_cell u_cell (
      .clk         (clk),
      .item        (in_data),
      .wr          (wr),
      .occupied    (occ[i]),
      .left_le     (left_le),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .flags       (flags[i]),
      .entry       (entry[i]),
      .entry_nxt   (entry_nxt[i])
    );
  end

  // Count, result and handshake
  sli_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .flags     (flags),
    .head_nxt  (entry_nxt[0]),
    .occ       (occ),
    .wr        (wr)
  );

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the sorted list insert/delete block.
`timescale 1ns / 100ps

module tb_top;
  import sli_pkg::*;

  localparam int RANDOM_WORDS   = 500;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int IDLE_PCT       = 19;
  localparam int REPORT_MAX     = 10;

  localparam logic signed [VAL_W-1:0] MIN_VAL = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] MAX_VAL = 32'sh7fff_ffff;

  typedef struct {
    in_item_t  word;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // Shadow copy of the sorted store
  logic signed [VAL_W-1:0] list_vals [DEPTH];
  int                      list_len;

  out_item_t pending_results [$];
  dir_row_t  directed_rows [$];
  int        mismatches;
  int        quiet_cycles;
  bit        calm;

  sorted_list_insert_delete uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Free-running clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Apply one word to the shadow store and return the result it should cause
  function automatic out_item_t update_sorted_store(input in_item_t w);
    out_item_t r;
    int        p;
    int        k;
    bit        hit;
    r   = '0;
    p   = 0;
    hit = 1'b0;
    if (w.mode == MODE_INSERT) begin
      if (list_len >= DEPTH) begin
        r.status = ST_DROPPED;
      end else begin
        // land after every entry less than or equal to the value
        while (p < list_len && list_vals[p] <= w.value) p++;
        for (k = list_len; k > p; k--) list_vals[k] = list_vals[k-1];
        list_vals[p] = w.value;
        list_len++;
        r.status = ST_INSERTED;
      end
    end else begin
      // remove the lowest-position equal entry
      for (k = 0; k < list_len && !hit; k++) begin
        if (list_vals[k] == w.value) begin
          hit = 1'b1;
          p   = k;
        end
      end
      if (hit) begin
        for (k = p; k + 1 < list_len; k++) list_vals[k] = list_vals[k+1];
        list_len--;
        r.status = ST_DELETED;
      end else begin
        p        = 0;
        r.status = ST_NOT_FOUND;
      end
    end
    r.position       = p[POS_W-1:0];
    r.entry_count    = list_len[CNT_OUT_W-1:0];
    r.smallest_valid = (list_len != 0);
    r.smallest_value = (list_len != 0) ? list_vals[0] : '0;
    return r;
  endfunction

  // Many small values so duplicates show up, plus extremes and full-range noise
  function automatic logic signed [VAL_W-1:0] random_value();
    int pick;
    logic signed [VAL_W-1:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      v = $urandom_range(0, 15) - 8;
    end else if (pick < 55) begin
      case ($urandom_range(0, 3))
        0:       v = MIN_VAL;
        1:       v = MAX_VAL;
        2:       v = '0;
        default: v = -1;
      endcase
    end else begin
      v = $urandom;
    end
    return v;
  endfunction

  task automatic add_row(input logic mode, input logic signed [VAL_W-1:0] value,
                         input bit typed, input out_item_t res);
    dir_row_t row;
    row.word.mode  = mode;
    row.word.value = value;
    row.typed      = typed;
    row.res        = res;
    directed_rows.push_back(row);
  endtask

  // Present one word, hold it until taken, then log its expected result
  task automatic send_word(input in_item_t w, input bit typed, input out_item_t typed_res);
    out_item_t res;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = update_sorted_store(w);
    pending_results.push_back(typed ? typed_res : res);
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input out_item_t want,
                                 input out_item_t got);
    mismatches++;
    if (mismatches <= REPORT_MAX)
      $display("mismatch (%s) at %0t: expected st=%0d pos=%0d cnt=%0d vld=%0b min=%0d, got st=%0d pos=%0d cnt=%0d vld=%0b min=%0d",
               what, $realtime,
               want.status, want.position, want.entry_count, want.smallest_valid,
               $signed(want.smallest_value),
               got.status, got.position, got.entry_count, got.smallest_valid,
               $signed(got.smallest_value));
  endtask

  // Random backpressure on the result side
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
  end

  // Check each taken result against the oldest expectation; watch for a hang
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("no word expected", '0, out_data);
      end else begin
        want = pending_results.pop_front();
        if (want.status != out_data.status ||
            want.position != out_data.position ||
            want.entry_count != out_data.entry_count ||
            want.smallest_valid != out_data.smallest_valid ||
            want.smallest_value != out_data.smallest_value)
          report_mismatch("field", want, out_data);
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random traffic, drain
  initial begin : main_seq
    in_item_t w;
    int       n;
    bit       filling;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    out_stall    = 1'b0;
    calm         = 1'b0;
    list_len     = 0;
    mismatches   = 0;
    quiet_cycles = 0;
    filling      = 1'b1;

    // empty store, both extremes, duplicates, absent value
    add_row(MODE_DELETE, '0, 1'b1, '{ST_NOT_FOUND, 4'd0, 5'd0, 1'b0, 32'sd0});
    add_row(MODE_INSERT, MIN_VAL, 1'b1, '{ST_INSERTED, 4'd0, 5'd1, 1'b1, MIN_VAL});
    add_row(MODE_INSERT, MAX_VAL, 1'b1, '{ST_INSERTED, 4'd1, 5'd2, 1'b1, MIN_VAL});
    add_row(MODE_INSERT, 0, 1'b0, '0);
    add_row(MODE_INSERT, 0, 1'b0, '0);
    add_row(MODE_INSERT, -1, 1'b0, '0);
    add_row(MODE_DELETE, 0, 1'b0, '0);
    add_row(MODE_DELETE, 12345, 1'b0, '0);
    // fill to capacity, with a run of equal values
    add_row(MODE_INSERT, 5, 1'b0, '0);
    add_row(MODE_INSERT, 5, 1'b0, '0);
    add_row(MODE_INSERT, 5, 1'b0, '0);
    add_row(MODE_INSERT, -100, 1'b0, '0);
    add_row(MODE_INSERT, 100, 1'b0, '0);
    add_row(MODE_INSERT, 32'sh5555_5555, 1'b0, '0);
    add_row(MODE_INSERT, 32'shaaaa_aaaa, 1'b0, '0);
    add_row(MODE_INSERT, -2, 1'b0, '0);
    add_row(MODE_INSERT, 2, 1'b0, '0);
    add_row(MODE_INSERT, 1000, 1'b0, '0);
    add_row(MODE_INSERT, -1000, 1'b0, '0);
    add_row(MODE_INSERT, 7, 1'b0, '0);
    // full store drops the insert; then remove from both ends
    add_row(MODE_INSERT, 42, 1'b1, '{ST_DROPPED, 4'd0, 5'd16, 1'b1, MIN_VAL});
    add_row(MODE_DELETE, MAX_VAL, 1'b1, '{ST_DELETED, 4'd15, 5'd15, 1'b1, MIN_VAL});
    add_row(MODE_DELETE, MIN_VAL, 1'b0, '0);
    add_row(MODE_DELETE, MAX_VAL, 1'b0, '0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed_rows[i])
      send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].res);

    // Random traffic in fill and drain phases so the store swings full and empty
    for (n = 0; n < RANDOM_WORDS; n++) begin
      calm = (n >= 200 && n < 320);
      if (list_len == DEPTH && $urandom_range(0, 99) < 30) filling = 1'b0;
      else if (list_len == 0) filling = 1'b1;
      else if ($urandom_range(0, 99) < 4) filling = !filling;
      w.mode = ($urandom_range(0, 99) < (filling ? 78 : 22)) ? MODE_INSERT : MODE_DELETE;
      if (w.mode == MODE_DELETE && list_len != 0 && $urandom_range(0, 99) < 75)
        w.value = list_vals[$urandom_range(0, list_len - 1)];
      else
        w.value = random_value();
      send_word(w, 1'b0, '0);
    end
    calm = 1'b0;

    // Drain outstanding results, then let the block settle
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- sorted_list_insert_delete.f -----
+incdir+rtl
rtl/sli_pkg.sv
rtl/sli_cell.sv
rtl/sli_ctrl.sv
rtl/sorted_list_insert_delete.sv
tb/tb_top.sv
